// ----- src/assert_macros.svh -----
// Assertion macros used by the core module of the positioner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, disabled during reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication check: the consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sslp_pkg.sv -----
// Types, constants and the duty table of the slew limited servo positioner.
package sslp_pkg;

    localparam int ANGLE_MAX     = 180;
    localparam int ANGLE_RESET   = 90;
    localparam int PULSE_MIN_US  = 500;
    localparam int PULSE_SPAN_US = 2000;
    localparam int PERIOD_US     = 1000000 / 50;

    localparam int DUTY_BITS_DEFAULT = 14;

    localparam int DUTY_W     = 14;
    localparam int ANGLE_W    = 8;
    localparam int TARGET_W   = 10;
    localparam int STEP_W     = 8;
    localparam int INTERVAL_W = 16;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    typedef enum logic {
        KIND_MOVE = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef struct packed {
        logic [ANGLE_W-1:0]    cur;
        logic [ANGLE_W-1:0]    goal;
        logic [STEP_W-1:0]     step;
        logic [INTERVAL_W-1:0] interval;
        logic [INTERVAL_W-1:0] elapsed;
    } t_state;

    typedef struct packed {
        t_kind                kind;
        logic [TARGET_W-1:0]  target;
        logic [STEP_W-1:0]    step;
        logic [INTERVAL_W-1:0] interval;
    } t_item;

    typedef logic [DUTY_W-1:0] t_duty_lut [0:ANGLE_MAX];

    // Duty value for every angle, evaluated at elaboration.
    function automatic t_duty_lut build_duty_lut(input int unsigned duty_bits);
        t_duty_lut       lut;
        longint unsigned pulse;
        longint unsigned full;
        full = (longint'(1) << duty_bits) - 1;
        for (int a = 0; a <= ANGLE_MAX; a++) begin
            pulse  = longint'(PULSE_MIN_US) + (longint'(a) * PULSE_SPAN_US) / ANGLE_MAX;
            lut[a] = DUTY_W'((pulse * full) / PERIOD_US);
        end
        return lut;
    endfunction

endpackage

// ----- src/servo_slew_limited_positioner_core.sv -----
// Slew limited servo positioner: command and tick stream in, angle and duty stream out.
//
// Input stream: tuser[0] selects a move command (0) or a one millisecond tick (1).
// A move command carries a target angle, a step size and a step interval; the
// target is clamped to 0..180 degrees. A step size of zero jumps to the target
// and always produces a result. Ticks advance the elapsed counter and, once the
// interval is reached, move the angle one step toward the target.
// Output stream: one transfer for each change of angle and for each move with a
// step size of zero, with the angle and its PWM compare value for a 20 ms period
// at DUTY_BITS of resolution. A result appears on the output in the cycle after
// the input transfer. Throughput: one input item per cycle unless a result waits
// on a stalled receiver; the state update and the duty table lookup both finish in the
// cycle of the transfer. A single output register holds the result; the input is
// taken whenever that register is empty or is being read in the same cycle, so a
// stalled receiver holds the input off only while a result is waiting.
// Reset sets the angle to 90 degrees, clears the other state and produces no
// result.
`include "assert_macros.svh"

module servo_slew_limited_positioner_core #(
    parameter int DUTY_BITS = sslp_pkg::DUTY_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // target_angle[9:0], step_degrees[17:10], interval_ms[33:18], zero pad[39:34]
    input  logic [sslp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // kind[0]
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // duty[13:0], angle_now[21:14], zero pad[23:22]
    output logic [sslp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam sslp_pkg::t_duty_lut DUTY_LUT = sslp_pkg::build_duty_lut(DUTY_BITS);

    sslp_pkg::t_state r_state;
    sslp_pkg::t_state n_state;
    sslp_pkg::t_item  item;
    logic             emit;
    logic             s_fire;

    logic                           r_out_valid;
    logic [sslp_pkg::DUTY_W-1:0]    r_out_duty;
    logic [sslp_pkg::ANGLE_W-1:0]   r_out_angle;

    assign item.kind     = sslp_pkg::t_kind'(s_axis_tuser[0]);
    assign item.target   = s_axis_tdata[9:0];
    assign item.step     = s_axis_tdata[17:10];
    assign item.interval = s_axis_tdata[33:18];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    sslp_update u_update (
        .i_state (r_state),
        .i_item  (item),
        .o_state (n_state),
        .o_emit  (emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cur      <= sslp_pkg::ANGLE_W'(sslp_pkg::ANGLE_RESET);
            r_state.goal     <= '0;
            r_state.step     <= '0;
            r_state.interval <= '0;
            r_state.elapsed  <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (s_fire) begin
                r_state <= n_state;
            end
            if (s_fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && emit) begin
            r_out_duty  <= DUTY_LUT[n_state.cur];
            r_out_angle <= n_state.cur;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_angle, r_out_duty};

    `ASSERT_CLK(a_angle_in_range, i_clk, i_rst_n,
        r_state.cur <= sslp_pkg::ANGLE_W'(sslp_pkg::ANGLE_MAX) &&
        r_state.goal <= sslp_pkg::ANGLE_W'(sslp_pkg::ANGLE_MAX),
        "positioner angle or goal left the 0..180 range")
    `ASSERT_NEXT(a_smooth_cmd_holds_angle, i_clk, i_rst_n,
        s_fire && item.kind == sslp_pkg::KIND_MOVE && item.step != '0,
        $stable(r_state.cur),
        "a smoothing command moved the angle")
    `ASSERT_NEXT(a_emit_loads_output, i_clk, i_rst_n,
        s_fire && emit,
        m_axis_tvalid && r_out_angle == r_state.cur,
        "a result was not loaded with the new angle")

endmodule

// ----- src/sslp_update.sv -----
// Next-state logic of the positioner for one command or tick.
module sslp_update (
    input  sslp_pkg::t_state i_state,
    input  sslp_pkg::t_item  i_item,
    output sslp_pkg::t_state o_state,
    output logic             o_emit
);

    logic [sslp_pkg::ANGLE_W-1:0]    clamped;
    logic [sslp_pkg::INTERVAL_W-1:0] elapsed_inc;
    logic [sslp_pkg::ANGLE_W:0]      sum_up;
    logic [sslp_pkg::ANGLE_W-1:0]    diff_down;

    // Negative targets go to zero, large ones to the top of the range.
    always_comb begin
        if (i_item.target[sslp_pkg::TARGET_W-1]) begin
            clamped = '0;
        end else if (i_item.target[sslp_pkg::TARGET_W-2:0]
                     > (sslp_pkg::TARGET_W-1)'(sslp_pkg::ANGLE_MAX)) begin
            clamped = sslp_pkg::ANGLE_W'(sslp_pkg::ANGLE_MAX);
        end else begin
            clamped = i_item.target[sslp_pkg::ANGLE_W-1:0];
        end
    end

    assign elapsed_inc = (&i_state.elapsed) ? i_state.elapsed
                                            : i_state.elapsed + 1'b1;
    assign sum_up      = {1'b0, i_state.cur} + {1'b0, i_state.step};
    assign diff_down   = i_state.cur - i_state.goal;

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        if (i_item.kind == sslp_pkg::KIND_MOVE) begin
            o_state.goal     = clamped;
            o_state.step     = i_item.step;
            o_state.interval = i_item.interval;
            if (i_item.step == '0) begin
                o_state.cur = clamped;
                o_emit      = 1'b1;
            end
        end else if (i_state.step == '0 || elapsed_inc < i_state.interval) begin
            o_state.elapsed = elapsed_inc;
        end else begin
            o_state.elapsed = '0;
            if (i_state.cur < i_state.goal) begin
                o_state.cur = (sum_up > {1'b0, i_state.goal}) ? i_state.goal
                                                              : sum_up[sslp_pkg::ANGLE_W-1:0];
                o_emit      = 1'b1;
            end else if (i_state.cur > i_state.goal) begin
                o_state.cur = (diff_down <= i_state.step) ? i_state.goal
                                                          : i_state.cur - i_state.step;
                o_emit      = 1'b1;
            end
        end
    end

endmodule
